### sv/dgcd_pkg.sv
`timescale 1ns / 1ps

package dgcd_pkg;

    localparam int NODE_FIELD_W = 8;
    localparam int COUNT_W      = 9;
    localparam int CFG_INDEX_W  = 1;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_DETECT = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_NODE = 1'b1;

    localparam logic [COUNT_W-1:0]      NODE_COUNT_RST = 9'd7;
    localparam logic [NODE_FIELD_W-1:0] START_NODE_RST = 8'd0;

    typedef enum logic [3:0] {
        S_CLR_HT,
        S_IDLE,
        S_ADD_LINK,
        S_ADD_TAIL,
        S_DET_CLR,
        S_DET_INIT,
        S_DET_HEAD,
        S_DET_EDGE,
        S_DET_POP,
        S_DET_TGT,
        S_DET_MARK
    } t_state;

endpackage

### sv/directed_graph_cycle_detect.sv
`timescale 1ns / 1ps
// add edge: S_ADD_LINK (and S_ADD_TAIL when the source list is not empty), then the strobe
// detect: S_DET_CLR clears all MAX_NODES marks, S_DET_INIT, S_DET_HEAD set up; per edge:
//   S_DET_EDGE, S_DET_TGT, S_DET_MARK (not if out of range); push S_DET_HEAD, pop S_DET_POP
// dropped edge or start node out of range: strobe in the next cycle, o_busy stays low
// otherwise o_busy is high from acceptance until the result strobe, one item at a time
// after reset all MAX_NODES list head/tail entries are swept to empty, o_busy high
module directed_graph_cycle_detect
    import dgcd_pkg::*;
#(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic                    i_kind,
    input  logic [NODE_FIELD_W-1:0] i_from_node,
    input  logic [NODE_FIELD_W-1:0] i_to_node,
    output logic                    o_done,
    output logic                    o_cycle_found,
    output logic                    o_edge_dropped,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [COUNT_W-1:0]      i_cfg_data
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int AW  = $clog2(MAX_EDGES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int SPW = $clog2(MAX_NODES + 1);
    localparam int LW  = (NW + 1 > COUNT_W) ? NW + 1 : COUNT_W;
    localparam int SW  = NW + EW;
    localparam logic [EW-1:0] EDGE_NIL  = EW'(MAX_EDGES);
    localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

    // configuration
    logic [COUNT_W-1:0]      r_node_count;
    logic [NODE_FIELD_W-1:0] r_start_node;

    // control
    t_state           r_state, n_state;
    logic [NW-1:0]    r_idx, n_idx;
    logic [EW-1:0]    r_edge_total, n_edge_total;
    logic [SPW-1:0]   r_sp, n_sp;
    logic [NW-1:0]    r_top_node, n_top_node;
    logic [EW-1:0]    r_top_cur, n_top_cur;
    logic [NW-1:0]    r_from, n_from;
    logic [NW-1:0]    r_to, n_to;
    logic [NW-1:0]    r_t, n_t;
    logic [EW-1:0]    r_link_tail, n_link_tail;
    logic [EW-1:0]    r_new_edge, n_new_edge;
    logic             r_done, n_done;
    logic             r_cycle, n_cycle;
    logic             r_drop, n_drop;

    // memories
    logic [2*EW-1:0]  r_ht_mem [MAX_NODES];
    logic [2*EW-1:0]  r_ht_rd;
    logic             ht_we;
    logic [NW-1:0]    ht_waddr, ht_raddr;
    logic [2*EW-1:0]  ht_wdata;

    logic [NW-1:0]    r_tgt_mem [MAX_EDGES];
    logic [NW-1:0]    r_tgt_rd;
    logic             tgt_we;
    logic [AW-1:0]    tgt_waddr;
    logic [NW-1:0]    tgt_wdata;

    logic [EW-1:0]    r_nxt_mem [MAX_EDGES];
    logic [EW-1:0]    r_nxt_rd;
    logic             nxt_we;
    logic [AW-1:0]    nxt_waddr;
    logic [EW-1:0]    nxt_wdata;
    logic [AW-1:0]    edge_raddr;

    // mark bit 1 is visited, bit 0 is on the current path
    logic [1:0]       r_mark_mem [MAX_NODES];
    logic [1:0]       r_mark_rd;
    logic             mark_we;
    logic [NW-1:0]    mark_waddr, mark_raddr;
    logic [1:0]       mark_wdata;

    logic [SW-1:0]    r_stk_mem [MAX_NODES];
    logic [SW-1:0]    r_stk_rd;
    logic             stk_we;
    logic [NW-1:0]    stk_waddr, stk_raddr;
    logic [SW-1:0]    stk_wdata;

    logic [LW-1:0]    w_live;
    logic             w_from_ok, w_to_ok, w_start_ok, w_full;
    logic [EW-1:0]    w_head, w_tail;

    assign w_live = (LW'(r_node_count) > LW'(MAX_NODES)) ? LW'(MAX_NODES)
                                                          : LW'(r_node_count);
    assign w_from_ok  = LW'(i_from_node) < w_live;
    assign w_to_ok    = LW'(i_to_node) < w_live;
    assign w_start_ok = LW'(r_start_node) < w_live;
    assign w_full     = r_edge_total >= EDGE_NIL;
    assign w_head     = r_ht_rd[2*EW-1:EW];
    assign w_tail     = r_ht_rd[EW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_start_node <= START_NODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                CFG_START_NODE: r_start_node <= i_cfg_data[NODE_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR_HT;
            r_idx        <= '0;
            r_edge_total <= '0;
            r_sp         <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_edge_total <= n_edge_total;
            r_sp         <= n_sp;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_node  <= n_top_node;
        r_top_cur   <= n_top_cur;
        r_from      <= n_from;
        r_to        <= n_to;
        r_t         <= n_t;
        r_link_tail <= n_link_tail;
        r_new_edge  <= n_new_edge;
        r_cycle     <= n_cycle;
        r_drop      <= n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (ht_we) begin
            r_ht_mem[ht_waddr] <= ht_wdata;
        end
        r_ht_rd <= r_ht_mem[ht_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[tgt_waddr] <= tgt_wdata;
        end
        r_tgt_rd <= r_tgt_mem[edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            r_nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        r_nxt_rd <= r_nxt_mem[edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[mark_waddr] <= mark_wdata;
        end
        r_mark_rd <= r_mark_mem[mark_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= r_stk_mem[stk_raddr];
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_edge_total = r_edge_total;
        n_sp         = r_sp;
        n_top_node   = r_top_node;
        n_top_cur    = r_top_cur;
        n_from       = r_from;
        n_to         = r_to;
        n_t          = r_t;
        n_link_tail  = r_link_tail;
        n_new_edge   = r_new_edge;
        n_done       = 1'b0;
        n_cycle      = r_cycle;
        n_drop       = r_drop;

        ht_we      = 1'b0;
        ht_waddr   = r_from;
        ht_wdata   = {EDGE_NIL, EDGE_NIL};
        ht_raddr   = NW'(i_from_node);
        tgt_we     = 1'b0;
        tgt_waddr  = AW'(r_edge_total);
        tgt_wdata  = r_to;
        nxt_we     = 1'b0;
        nxt_waddr  = AW'(r_edge_total);
        nxt_wdata  = EDGE_NIL;
        edge_raddr = AW'(r_top_cur);
        mark_we    = 1'b0;
        mark_waddr = r_idx;
        mark_wdata = 2'b00;
        mark_raddr = r_tgt_rd;
        stk_we     = 1'b0;
        stk_waddr  = NW'(r_sp - SPW'(1));
        stk_wdata  = {r_top_node, r_top_cur};
        stk_raddr  = NW'(r_sp - SPW'(2));

        case (r_state)
            S_CLR_HT: begin
                ht_we    = 1'b1;
                ht_waddr = r_idx;
                if (r_idx == LAST_NODE) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + NW'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind == KIND_ADD) begin
                        if (!w_from_ok || !w_to_ok || w_full) begin
                            n_done  = 1'b1;
                            n_cycle = 1'b0;
                            n_drop  = 1'b1;
                        end else begin
                            n_from  = NW'(i_from_node);
                            n_to    = NW'(i_to_node);
                            n_state = S_ADD_LINK;
                        end
                    end else begin
                        if (!w_start_ok) begin
                            n_done  = 1'b1;
                            n_cycle = 1'b0;
                            n_drop  = 1'b0;
                        end else begin
                            n_idx   = '0;
                            n_state = S_DET_CLR;
                        end
                    end
                end
            end
            S_ADD_LINK: begin
                tgt_we       = 1'b1;
                nxt_we       = 1'b1;
                ht_we        = 1'b1;
                n_edge_total = r_edge_total + EW'(1);
                n_new_edge   = r_edge_total;
                if (w_head == EDGE_NIL) begin
                    ht_wdata = {r_edge_total, r_edge_total};
                    n_done   = 1'b1;
                    n_cycle  = 1'b0;
                    n_drop   = 1'b0;
                    n_state  = S_IDLE;
                end else begin
                    ht_wdata    = {w_head, r_edge_total};
                    n_link_tail = w_tail;
                    n_state     = S_ADD_TAIL;
                end
            end
            S_ADD_TAIL: begin
                // chain the old tail of the source list to the new edge
                nxt_we    = 1'b1;
                nxt_waddr = AW'(r_link_tail);
                nxt_wdata = r_new_edge;
                n_done    = 1'b1;
                n_cycle   = 1'b0;
                n_drop    = 1'b0;
                n_state   = S_IDLE;
            end
            S_DET_CLR: begin
                mark_we = 1'b1;
                if (r_idx == LAST_NODE) begin
                    n_idx   = '0;
                    n_state = S_DET_INIT;
                end else begin
                    n_idx = r_idx + NW'(1);
                end
            end
            S_DET_INIT: begin
                mark_we    = 1'b1;
                mark_waddr = NW'(r_start_node);
                mark_wdata = 2'b11;
                ht_raddr   = NW'(r_start_node);
                n_top_node = NW'(r_start_node);
                n_sp       = SPW'(1);
                n_state    = S_DET_HEAD;
            end
            S_DET_HEAD: begin
                n_top_cur = w_head;
                n_state   = S_DET_EDGE;
            end
            S_DET_EDGE: begin
                if (r_top_cur >= r_edge_total) begin
                    // list exhausted: leave the path and pop
                    mark_we    = 1'b1;
                    mark_waddr = r_top_node;
                    mark_wdata = 2'b10;
                    n_sp       = r_sp - SPW'(1);
                    if (r_sp == SPW'(1)) begin
                        n_done  = 1'b1;
                        n_cycle = 1'b0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DET_POP;
                    end
                end else begin
                    n_state = S_DET_TGT;
                end
            end
            S_DET_POP: begin
                n_top_node = r_stk_rd[SW-1:EW];
                n_top_cur  = r_stk_rd[EW-1:0];
                n_state    = S_DET_EDGE;
            end
            S_DET_TGT: begin
                n_top_cur = r_nxt_rd;
                n_t       = r_tgt_rd;
                // targets left over from a larger node count are skipped
                if (LW'(r_tgt_rd) >= w_live) begin
                    n_state = S_DET_EDGE;
                end else begin
                    n_state = S_DET_MARK;
                end
            end
            S_DET_MARK: begin
                if (r_mark_rd[0]) begin
                    n_done  = 1'b1;
                    n_cycle = 1'b1;
                    n_drop  = 1'b0;
                    n_state = S_IDLE;
                end else if (!r_mark_rd[1] && (r_sp < SPW'(MAX_NODES))) begin
                    mark_we    = 1'b1;
                    mark_waddr = r_t;
                    mark_wdata = 2'b11;
                    stk_we     = 1'b1;
                    ht_raddr   = r_t;
                    n_top_node = r_t;
                    n_sp       = r_sp + SPW'(1);
                    n_state    = S_DET_HEAD;
                end else begin
                    n_state = S_DET_EDGE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_cycle_found  = r_cycle;
    assign o_edge_dropped = r_drop;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import dgcd_pkg::*;

    localparam int MAX_NODES    = 256;
    localparam int MAX_EDGES    = 1024;
    localparam int EDGE_W       = $clog2(MAX_EDGES + 1);
    localparam int PHASE_ITEMS  = 150;
    localparam int LIMIT_CYCLES = 30_000_000;

    localparam logic [EDGE_W-1:0]  EDGE_NIL   = EDGE_W'(MAX_EDGES);
    localparam logic [COUNT_W-1:0] NODE_LIMIT = COUNT_W'(MAX_NODES);

    typedef struct packed {
        logic cycle_found;
        logic edge_dropped;
    } t_graph_result;

    class graph_scoreboard;
        logic [COUNT_W-1:0]      node_count;
        logic [NODE_FIELD_W-1:0] start_node;
        logic [NODE_FIELD_W-1:0] edge_target [MAX_EDGES];
        logic [EDGE_W-1:0]       edge_next   [MAX_EDGES];
        logic [EDGE_W-1:0]       list_head   [MAX_NODES];
        logic [EDGE_W-1:0]       list_tail   [MAX_NODES];
        logic [EDGE_W-1:0]       edge_total;
        bit                      visited     [MAX_NODES];
        bit                      on_path     [MAX_NODES];
        logic [NODE_FIELD_W-1:0] path_node   [MAX_NODES];
        logic [EDGE_W-1:0]       path_cursor [MAX_NODES];
        t_graph_result           pending_outcomes [$];
        int unsigned             mismatches;
        int unsigned             adds;
        int unsigned             drops;
        int unsigned             detects;
        int unsigned             cycles;

        function new();
            node_count = NODE_COUNT_RST;
            start_node = START_NODE_RST;
            edge_total = '0;
            foreach (list_head[i]) begin
                list_head[i] = EDGE_NIL;
                list_tail[i] = EDGE_NIL;
            end
            mismatches = 0;
            adds       = 0;
            drops      = 0;
            detects    = 0;
            cycles     = 0;
        endfunction

        function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [COUNT_W-1:0] value);
            if (idx == CFG_NODE_COUNT) begin
                node_count = value;
            end else if (idx == CFG_START_NODE) begin
                start_node = value[NODE_FIELD_W-1:0];
            end
        endfunction

        function logic [COUNT_W-1:0] live_count();
            return (node_count > NODE_LIMIT) ? NODE_LIMIT : node_count;
        endfunction

        function bit store_edge(logic [NODE_FIELD_W-1:0] src, logic [NODE_FIELD_W-1:0] dst);
            logic [COUNT_W-1:0] n;
            logic [EDGE_W-1:0]  slot;
            n = live_count();
            if ({1'b0, src} >= n || {1'b0, dst} >= n || edge_total >= EDGE_NIL) begin
                return 1'b1;
            end
            slot = edge_total;
            edge_target[slot] = dst;
            edge_next[slot]   = EDGE_NIL;
            if (list_head[src] == EDGE_NIL) begin
                list_head[src] = slot;
            end else begin
                edge_next[list_tail[src]] = slot;
            end
            list_tail[src] = slot;
            edge_total = slot + 1'b1;
            return 1'b0;
        endfunction

        // depth-first walk with an explicit stack of (node, next edge) pairs
        function bit walk_for_cycle();
            logic [COUNT_W-1:0]      n;
            logic [EDGE_W-1:0]       e;
            logic [NODE_FIELD_W-1:0] t;
            int                      sp;
            n = live_count();
            foreach (visited[i]) begin
                visited[i] = 1'b0;
                on_path[i] = 1'b0;
            end
            if ({1'b0, start_node} >= n) begin
                return 1'b0;
            end
            visited[start_node] = 1'b1;
            on_path[start_node] = 1'b1;
            path_node[0]   = start_node;
            path_cursor[0] = list_head[start_node];
            sp = 1;
            while (sp > 0) begin
                e = path_cursor[sp-1];
                if (e >= edge_total) begin
                    on_path[path_node[sp-1]] = 1'b0;
                    sp--;
                    continue;
                end
                path_cursor[sp-1] = edge_next[e];
                t = edge_target[e];
                // edges kept from a larger node count are skipped
                if ({1'b0, t} >= n) begin
                    continue;
                end
                if (on_path[t]) begin
                    return 1'b1;
                end
                if (!visited[t] && sp < MAX_NODES) begin
                    visited[t] = 1'b1;
                    on_path[t] = 1'b1;
                    path_node[sp]   = t;
                    path_cursor[sp] = list_head[t];
                    sp++;
                end
            end
            return 1'b0;
        endfunction

        function void note_item(logic kind, logic [NODE_FIELD_W-1:0] src,
                                logic [NODE_FIELD_W-1:0] dst);
            t_graph_result r;
            r = '0;
            if (kind == KIND_ADD) begin
                r.edge_dropped = store_edge(src, dst);
                adds++;
                if (r.edge_dropped) drops++;
            end else begin
                r.cycle_found = walk_for_cycle();
                detects++;
                if (r.cycle_found) cycles++;
            end
            pending_outcomes = {pending_outcomes, r};
        endfunction

        function void report(string field, logic want, logic got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s mismatch, expected %0b, got %0b", $time, field, want, got);
            end
        endfunction

        function void check_result(logic cycle_found, logic edge_dropped);
            t_graph_result want;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with nothing expected, cycle_found=%0b edge_dropped=%0b",
                             $time, cycle_found, edge_dropped);
                end
                return;
            end
            want = pending_outcomes.pop_front();
            if (cycle_found !== want.cycle_found) begin
                report("cycle_found", want.cycle_found, cycle_found);
            end
            if (edge_dropped !== want.edge_dropped) begin
                report("edge_dropped", want.edge_dropped, edge_dropped);
            end
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_start     = 1'b0;
    logic                    o_busy;
    logic                    i_kind      = KIND_ADD;
    logic [NODE_FIELD_W-1:0] i_from_node = '0;
    logic [NODE_FIELD_W-1:0] i_to_node   = '0;
    logic                    o_done;
    logic                    o_cycle_found;
    logic                    o_edge_dropped;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = CFG_NODE_COUNT;
    logic [COUNT_W-1:0]      i_cfg_data  = '0;

    graph_scoreboard sb;
    int unsigned     cycle_count = 0;

    directed_graph_cycle_detect #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_from_node    (i_from_node),
        .i_to_node      (i_to_node),
        .o_done         (o_done),
        .o_cycle_found  (o_cycle_found),
        .o_edge_dropped (o_edge_dropped),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            sb.check_result(o_cycle_found, o_edge_dropped);
        end
    end

    function automatic int draw_gap(int pct);
        int n;
        n = 0;
        while (n < 60 && $urandom_range(99) < pct) n++;
        return n;
    endfunction

    task automatic send_item(logic kind, logic [NODE_FIELD_W-1:0] src,
                             logic [NODE_FIELD_W-1:0] dst, int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_kind      <= kind;
        i_from_node <= src;
        i_to_node   <= dst;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        sb.note_item(kind, src, dst);
    endtask

    // hold off new items until every outstanding result has come back
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_outcomes.size() != 0 || o_busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COUNT_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.apply_reg(idx, value);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_edge_item(int src, int dst);
        send_item(KIND_ADD, NODE_FIELD_W'(src), NODE_FIELD_W'(dst), 0);
    endtask

    task automatic detect_item();
        send_item(KIND_DETECT, NODE_FIELD_W'($urandom_range(255)),
                  NODE_FIELD_W'($urandom_range(255)), 0);
    endtask

    // mostly forward edges inside [base, base+span) so the region stays acyclic
    // until an occasional back edge closes a loop
    task automatic run_phase(int base, int span, int count, int idle_pct, int n_items,
                             bit fill);
        int sent;
        int past_full;
        int gap;
        int roll;
        int src;
        int dst;
        int det_pct;
        int pick;
        sent      = 0;
        past_full = 0;
        det_pct   = fill ? 10 : 20;
        write_reg(CFG_NODE_COUNT, COUNT_W'(count));
        write_reg(CFG_START_NODE, COUNT_W'(base));
        while (fill ? (past_full < 30) : (sent < n_items)) begin
            gap  = draw_gap(idle_pct);
            roll = $urandom_range(99);
            if (roll < det_pct) begin
                if ($urandom_range(1) == 1) begin
                    if ($urandom_range(5) == 0) begin
                        pick = $urandom_range(255);
                    end else begin
                        pick = base + $urandom_range(span - 1);
                    end
                    write_reg(CFG_START_NODE, COUNT_W'(pick));
                end
                send_item(KIND_DETECT, NODE_FIELD_W'($urandom_range(255)),
                          NODE_FIELD_W'($urandom_range(255)), gap);
            end else if (roll < det_pct + 7) begin
                send_item(KIND_ADD, NODE_FIELD_W'($urandom_range(255)),
                          NODE_FIELD_W'($urandom_range(255)), gap);
            end else begin
                if ($urandom_range(99) < 2) begin
                    src = base + $urandom_range(span - 1);
                    dst = base + $urandom_range(src - base);
                end else begin
                    src = base + $urandom_range(span - 2);
                    dst = src + 1 + $urandom_range(base + span - 2 - src);
                end
                send_item(KIND_ADD, NODE_FIELD_W'(src), NODE_FIELD_W'(dst), gap);
            end
            if ($urandom_range(99) == 0) begin
                wait_drained();
            end
            sent++;
            if (fill && sb.edge_total >= EDGE_NIL) past_full++;
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // list memories are swept after reset with busy high
        repeat (2) @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);

        // reset settings: seven nodes, walk from node 0
        detect_item();
        add_edge_item(0, 1);
        add_edge_item(1, 2);
        detect_item();
        add_edge_item(2, 0);
        detect_item();
        add_edge_item(7, 0);
        add_edge_item(0, 7);
        add_edge_item(255, 255);
        write_reg(CFG_NODE_COUNT, NODE_LIMIT);
        write_reg(CFG_START_NODE, COUNT_W'(255));
        add_edge_item(255, 255);
        detect_item();
        add_edge_item(0, 255);
        write_reg(CFG_START_NODE, COUNT_W'(3));
        detect_item();
        // shrink the graph under existing edges
        write_reg(CFG_NODE_COUNT, COUNT_W'(2));
        write_reg(CFG_START_NODE, COUNT_W'(0));
        detect_item();
        write_reg(CFG_START_NODE, COUNT_W'(5));
        detect_item();
        write_reg(CFG_NODE_COUNT, COUNT_W'(0));
        add_edge_item(0, 0);
        detect_item();
        // count above the node limit is clamped
        write_reg(CFG_NODE_COUNT, COUNT_W'(511));
        add_edge_item(3, 4);
        write_reg(CFG_NODE_COUNT, COUNT_W'(1));
        write_reg(CFG_START_NODE, COUNT_W'(0));
        add_edge_item(0, 0);
        detect_item();

        run_phase(8, 16, 256, 0, PHASE_ITEMS, 1'b0);
        run_phase(8, 16, 16, 83, PHASE_ITEMS, 1'b0);
        run_phase(40, 48, 511, 0, PHASE_ITEMS, 1'b0);
        run_phase(100, 12, 112, 36, PHASE_ITEMS, 1'b0);
        run_phase(140, 100, 256, 83, PHASE_ITEMS, 1'b0);
        // keep adding until the edge store is full, then a little beyond
        run_phase(200, 56, 256, 0, 0, 1'b1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d edge adds (%0d rejected) and %0d detects (%0d with a cycle)",
                 sb.adds, sb.drops, sb.detects, sb.cycles);
        $display("edge store reached %0d of %0d entries, node counts 0 to 511, %0d mismatches",
                 sb.edge_total, MAX_EDGES, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
